[src/app_pp_pkg.sv]
// Package for the application packet parser.
// Holds control codes, parse phase codes, status and kind codes and the result type.
// No dependencies.
package app_pp_pkg;

    localparam logic [7:0] CB_DATA    = 8'h02;
    localparam logic [7:0] CB_START   = 8'h01;
    localparam logic [7:0] CB_END     = 8'h03;
    localparam logic [7:0] TLV_SIZE   = 8'h00;
    localparam logic [7:0] TLV_NAME   = 8'h01;

    localparam logic [2:0] PH_CTRL     = 3'd0;
    localparam logic [2:0] PH_LEN_HI   = 3'd1;
    localparam logic [2:0] PH_LEN_LO   = 3'd2;
    localparam logic [2:0] PH_PAYLOAD  = 3'd3;
    localparam logic [2:0] PH_TLV_TYPE = 3'd4;
    localparam logic [2:0] PH_TLV_LEN  = 3'd5;
    localparam logic [2:0] PH_TLV_VAL  = 3'd6;
    localparam logic [2:0] PH_IGNORE   = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    localparam logic [1:0] BK_HEADER   = 2'd0;
    localparam logic [1:0] BK_PAYLOAD  = 2'd1;
    localparam logic [1:0] BK_FILENAME = 2'd2;
    localparam logic [1:0] BK_SKIPPED  = 2'd3;

    localparam logic [1:0] PK_DATA    = 2'd0;
    localparam logic [1:0] PK_START   = 2'd1;
    localparam logic [1:0] PK_END     = 2'd2;
    localparam logic [1:0] PK_INVALID = 2'd3;

    localparam int          COUNT_W   = 17;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]  byte_kind;
        logic [7:0]  byte_out;
        logic        packet_done;
        logic [1:0]  packet_kind;
        logic [1:0]  status;
        logic [63:0] file_size;
        logic [15:0] declared_length;
    } t_result;

endpackage

[src/app_pp_if.sv]
// Valid/ready channel interfaces of the application packet parser.
// Input carries packet bytes, output carries one result per byte; no dependencies.
interface app_pp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface app_pp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  byte_kind;
    logic [7:0]  byte_out;
    logic        packet_done;
    logic [1:0]  packet_kind;
    logic [1:0]  status;
    logic [63:0] file_size;
    logic [15:0] declared_length;

    modport source (output valid, output byte_kind, output byte_out, output packet_done,
                    output packet_kind, output status, output file_size,
                    output declared_length, input ready);
    modport sink   (input valid, input byte_kind, input byte_out, input packet_done,
                    input packet_kind, input status, input file_size,
                    input declared_length, output ready);
endinterface

[src/app_packet_parser_core.sv]
// Top level of the application packet parser: byte-serial parse of data and TLV packets.
// Depends on app_pp_pkg and the channel interfaces in app_pp_if.sv.
//
// Usage:
//   i_in carries one packet byte per item, with last_byte set on the final byte.
//   o_out returns exactly one result item for every input item, in order.
//   Each accepted item updates the parse state in the cycle it is accepted; its
//   result is registered in the output stage and shows on o_out from there.
//   Throughput is one item per cycle while the skid register is empty: the parse state
//   update is a single registered step, so a new item can be taken at every clock edge.
//   A two-entry output stage (result register plus skid register) sits between
//   the sides; i_in.ready is low only when both entries are full, and it comes
//   straight from the skid register.
//   When the receiver stalls, up to two results are held and input stops after
//   the second; nothing is dropped or repeated.
//   Reset (synchronous, active low) empties the output stage and returns the
//   parser to expecting a control byte.
module app_packet_parser_core
    import app_pp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    app_pp_in_if.sink        i_in,
    app_pp_out_if.source     o_out
);

    logic [2:0]         r_phase, n_phase;
    logic [1:0]         r_kind, n_kind;
    logic [15:0]        r_len, n_len;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [7:0]         r_rtype, n_rtype;
    logic [7:0]         r_rrem, n_rrem;
    logic [63:0]        r_size, n_size;
    logic [1:0]         r_err, n_err;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    t_result n_res;

    logic acc;
    logic out_take;
    logic trunc;
    logic [1:0] bkind;
    logic [7:0] bout;

    assign acc      = i_in.valid && i_in.ready;
    assign out_take = r_out_valid && o_out.ready;
    assign i_in.ready = !r_skid_valid;

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_len   = r_len;
        n_count = r_count;
        n_rtype = r_rtype;
        n_rrem  = r_rrem;
        n_size  = r_size;
        n_err   = r_err;
        trunc   = 1'b0;
        bkind   = BK_HEADER;
        bout    = 8'h00;

        case (r_phase)
            PH_CTRL: begin
                n_len   = 16'h0000;
                n_count = '0;
                n_size  = 64'h0;
                n_err   = ST_OK;
                if (i_in.byte_in == CB_DATA) begin
                    n_kind  = PK_DATA;
                    n_phase = PH_LEN_HI;
                end else if (i_in.byte_in == CB_START) begin
                    n_kind  = PK_START;
                    n_phase = PH_TLV_TYPE;
                end else if (i_in.byte_in == CB_END) begin
                    n_kind  = PK_END;
                    n_phase = PH_TLV_TYPE;
                end else begin
                    n_kind  = PK_INVALID;
                    n_err   = ST_BAD_TYPE;
                    n_phase = PH_IGNORE;
                end
            end
            PH_LEN_HI: begin
                n_len   = {i_in.byte_in, 8'h00};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = {r_len[15:8], i_in.byte_in};
                n_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                bkind = BK_PAYLOAD;
                bout  = i_in.byte_in;
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
            end
            PH_TLV_TYPE: begin
                n_rtype = i_in.byte_in;
                n_phase = PH_TLV_LEN;
                trunc   = 1'b1;
            end
            PH_TLV_LEN: begin
                n_rrem = i_in.byte_in;
                if (r_rtype == TLV_SIZE) begin
                    n_size = 64'h0;
                end
                if (i_in.byte_in == 8'h00) begin
                    n_phase = PH_TLV_TYPE;
                end else begin
                    n_phase = PH_TLV_VAL;
                    trunc   = 1'b1;
                end
            end
            PH_TLV_VAL: begin
                if (r_rtype == TLV_SIZE) begin
                    n_size = {r_size[55:0], i_in.byte_in};
                end else if (r_rtype == TLV_NAME) begin
                    bkind = BK_FILENAME;
                    bout  = i_in.byte_in;
                end else begin
                    bkind = BK_SKIPPED;
                end
                n_rrem = r_rrem - 1'b1;
                if (n_rrem == 8'h00) begin
                    n_phase = PH_TLV_TYPE;
                end else begin
                    trunc = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (i_in.last_byte) begin
            if (n_kind == PK_DATA) begin
                if (n_phase != PH_PAYLOAD || n_count != {1'b0, n_len}) begin
                    n_err = ST_MISMATCH;
                end
            end else if (n_kind != PK_INVALID) begin
                if (trunc) begin
                    n_err = ST_TRUNC;
                end
            end
            n_phase = PH_CTRL;
        end

        n_res.byte_kind       = bkind;
        n_res.byte_out        = bout;
        n_res.packet_done     = i_in.last_byte;
        n_res.packet_kind     = n_kind;
        n_res.status          = i_in.last_byte ? n_err : ST_OK;
        n_res.file_size       = n_size;
        n_res.declared_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CTRL;
            r_kind  <= PK_DATA;
            r_len   <= 16'h0000;
            r_count <= '0;
            r_rtype <= 8'h00;
            r_rrem  <= 8'h00;
            r_size  <= 64'h0;
            r_err   <= ST_OK;
        end else if (acc) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_len   <= n_len;
            r_count <= n_count;
            r_rtype <= n_rtype;
            r_rrem  <= n_rrem;
            r_size  <= n_size;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= acc;
                end else begin
                    r_out_valid  <= acc;
                end
            end else if (acc) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (acc) begin
                    r_skid <= n_res;
                end
            end else if (acc) begin
                r_out <= n_res;
            end
        end else if (acc) begin
            r_skid <= n_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.byte_kind       = r_out.byte_kind;
    assign o_out.byte_out        = r_out.byte_out;
    assign o_out.packet_done     = r_out.packet_done;
    assign o_out.packet_kind     = r_out.packet_kind;
    assign o_out.status          = r_out.status;
    assign o_out.file_size       = r_out.file_size;
    assign o_out.declared_length = r_out.declared_length;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty result register");

    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> r_out.packet_done)
        else $error("nonzero status on a result that does not end a packet");

    a_payload_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.byte_kind == BK_PAYLOAD) |-> (r_out.packet_kind == PK_DATA))
        else $error("payload item outside a data packet");

    a_ctrl_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.last_byte) |=> (r_phase == PH_CTRL))
        else $error("parser not expecting a control byte after packet end");

endmodule

[dv/tb_app_packet_parser_core.sv]
// Testbench for app_packet_parser_core: directed and random packet streams are checked
// against a cycle-free predictor of the parser, one result per byte, in order.
// Depends on app_pp_pkg, app_pp_if.sv and the parser core.
module tb_app_packet_parser_core;
    import app_pp_pkg::*;

    typedef logic [7:0] t_byte_queue[$];

    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_ITEMS   = 750;
    localparam int IDLE_PERCENT   = 23;
    localparam int MAX_REPORTS    = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    app_pp_in_if  in_if ();
    app_pp_out_if out_if ();

    app_packet_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #4 i_clk = ~i_clk;

    // Parser state as predicted
    logic [2:0]  ph        = PH_CTRL;
    logic [1:0]  kind_seen = PK_DATA;
    logic [15:0] len_decl  = '0;
    logic [16:0] pay_count = '0;
    logic [7:0]  rec_type  = '0;
    logic [7:0]  rec_left  = '0;
    logic [63:0] size_acc  = '0;
    logic [1:0]  err       = ST_OK;

    t_result expected_results[$];

    int cycle_count   = 0;
    int items_sent    = 0;
    int packets_sent  = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int hold_off_left = 0;
    bit idle_on       = 1'b1;

    function automatic t_result parse_step(input logic [7:0] b, input logic last);
        t_result r;
        logic    cut;
        r   = '0;
        cut = 1'b0;
        case (ph)
            PH_CTRL: begin
                len_decl  = '0;
                pay_count = '0;
                size_acc  = '0;
                err       = ST_OK;
                if (b == CB_DATA) begin
                    kind_seen = PK_DATA;
                    ph        = PH_LEN_HI;
                end else if (b == CB_START || b == CB_END) begin
                    kind_seen = (b == CB_START) ? PK_START : PK_END;
                    ph        = PH_TLV_TYPE;
                end else begin
                    kind_seen = PK_INVALID;
                    err       = ST_BAD_TYPE;
                    ph        = PH_IGNORE;
                end
            end
            PH_LEN_HI: begin
                len_decl = {b, 8'h00};
                ph       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_decl[7:0] = b;
                ph            = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                r.byte_kind = BK_PAYLOAD;
                r.byte_out  = b;
                if (pay_count != COUNT_MAX) pay_count = pay_count + 17'd1;
            end
            PH_TLV_TYPE: begin
                rec_type = b;
                ph       = PH_TLV_LEN;
                cut      = 1'b1;
            end
            PH_TLV_LEN: begin
                rec_left = b;
                if (rec_type == TLV_SIZE) size_acc = '0;
                if (b == 8'h00) begin
                    ph = PH_TLV_TYPE;
                end else begin
                    ph  = PH_TLV_VAL;
                    cut = 1'b1;
                end
            end
            PH_TLV_VAL: begin
                if (rec_type == TLV_SIZE) begin
                    size_acc = {size_acc[55:0], b};
                end else if (rec_type == TLV_NAME) begin
                    r.byte_kind = BK_FILENAME;
                    r.byte_out  = b;
                end else begin
                    r.byte_kind = BK_SKIPPED;
                end
                rec_left = rec_left - 8'd1;
                if (rec_left == 8'h00) ph = PH_TLV_TYPE;
                else cut = 1'b1;
            end
            default: ;
        endcase
        if (last) begin
            if (kind_seen == PK_DATA) begin
                if (ph != PH_PAYLOAD || pay_count != {1'b0, len_decl}) err = ST_MISMATCH;
            end else if (kind_seen != PK_INVALID) begin
                if (cut) err = ST_TRUNC;
            end
            ph = PH_CTRL;
        end
        r.packet_done     = last;
        r.packet_kind     = kind_seen;
        r.status          = last ? err : ST_OK;
        r.file_size       = size_acc;
        r.declared_length = len_decl;
        return r;
    endfunction

    // Entered and left just after a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                in_if.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_if.valid     <= 1'b1;
        in_if.byte_in   <= b;
        in_if.last_byte <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_results.push_back(parse_step(b, last));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_packet(input t_byte_queue pkt);
        for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
        packets_sent++;
    endtask

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s at result %0d: expected kind=%h out=%h done=%b pk=%h st=%h fs=%h dl=%h",
                     what, results_seen, want.byte_kind, want.byte_out, want.packet_done,
                     want.packet_kind, want.status, want.file_size, want.declared_length);
            $display("    actual kind=%h out=%h done=%b pk=%h st=%h fs=%h dl=%h",
                     got.byte_kind, got.byte_out, got.packet_done, got.packet_kind,
                     got.status, got.file_size, got.declared_length);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.byte_kind       = out_if.byte_kind;
            got.byte_out        = out_if.byte_out;
            got.packet_done     = out_if.packet_done;
            got.packet_kind     = out_if.packet_kind;
            got.status          = out_if.status;
            got.file_size       = out_if.file_size;
            got.declared_length = out_if.declared_length;
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got.byte_kind !== want.byte_kind || got.byte_out !== want.byte_out ||
                    got.packet_done !== want.packet_done ||
                    got.packet_kind !== want.packet_kind || got.status !== want.status ||
                    got.file_size !== want.file_size ||
                    got.declared_length !== want.declared_length)
                    note_mismatch("mismatch", want, got);
            end
            results_seen++;
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            out_if.ready <= 1'b0;
            hold_off_left--;
        end else if (idle_on) begin
            out_if.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    task automatic test_data_packets();
        t_byte_queue pkt;
        pkt = {CB_DATA, 8'h00, 8'h01, 8'hA5};
        send_packet(pkt);
        // overrun: one byte beyond a zero length
        pkt = {CB_DATA, 8'h00, 8'h00, 8'h5A};
        send_packet(pkt);
        // header cut short on the control byte, then on the high length byte
        pkt = {CB_DATA};
        send_packet(pkt);
        pkt = {CB_DATA, 8'hFF};
        send_packet(pkt);
    endtask

    task automatic test_control_packets();
        t_byte_queue pkt;
        pkt = {CB_START};
        send_packet(pkt);
        // zero-length size, then a filename
        pkt = {CB_END, TLV_SIZE, 8'h00, TLV_NAME, 8'h01, 8'h41};
        send_packet(pkt);
        // unknown record cut inside its value
        pkt = {CB_START, 8'h07, 8'h02, 8'hEE};
        send_packet(pkt);
        // size record cut inside its value keeps the received byte
        pkt = {CB_END, TLV_SIZE, 8'h02, 8'h12};
        send_packet(pkt);
    endtask

    task automatic test_invalid_packets();
        t_byte_queue pkt;
        pkt = {TLV_SIZE, 8'h13};
        send_packet(pkt);
        pkt = {8'hFF, CB_DATA, CB_START};
        send_packet(pkt);
    endtask

    task automatic test_backpressure();
        t_byte_queue pkt;
        pkt = {CB_DATA, 8'h00, 8'd21};
        repeat (21) pkt.push_back(8'($urandom_range(0, 255)));
        hold_off_left = 60;
        send_packet(pkt);
    endtask

    task automatic test_random_traffic();
        t_byte_queue pkt;
        int          counted;
        int          sel;
        int          n;
        int          rlen;
        int          r;
        logic [15:0] len;
        logic [7:0]  rtype;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pkt.delete();
            rlen = 0;
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                n   = $urandom_range(0, 8);
                len = 16'(n);
                r   = $urandom_range(0, 5);
                if (r == 0) len = 16'($urandom_range(0, 65535));
                else if (r == 1) len = 16'(n + 1);
                pkt.push_back(CB_DATA);
                pkt.push_back(len[15:8]);
                pkt.push_back(len[7:0]);
                repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
            end else if (sel < 80) begin
                pkt.push_back($urandom_range(0, 1) ? CB_START : CB_END);
                repeat ($urandom_range(0, 3)) begin
                    r = $urandom_range(0, 9);
                    rtype = (r < 4) ? TLV_SIZE : (r < 7) ? TLV_NAME :
                            8'($urandom_range(0, 255));
                    r = $urandom_range(0, 19);
                    rlen = (r == 0) ? $urandom_range(128, 255) :
                           (r < 6) ? $urandom_range(9, 20) : $urandom_range(0, 8);
                    pkt.push_back(rtype);
                    pkt.push_back(8'(rlen));
                    repeat (rlen) pkt.push_back(8'($urandom_range(0, 255)));
                end
                if (rlen >= 128) begin
                    while (pkt.size() > 24) pkt.pop_back();
                end
            end else if (sel < 90) begin
                pkt.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(4, 255)));
                repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(0, 255)));
            end
            if (pkt.size() > 1 && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, pkt.size() - 1);
                while (pkt.size() > n) pkt.pop_back();
            end
            counted += pkt.size();
            send_packet(pkt);
        end
    endtask

    task automatic test_back_to_back();
        t_byte_queue pkt;
        idle_on = 1'b0;
        pkt = {CB_DATA, 8'h00, 8'd32};
        repeat (32) pkt.push_back(8'($urandom_range(0, 255)));
        send_packet(pkt);
        pkt = {CB_START, TLV_SIZE, 8'h03, 8'h01, 8'h02, 8'h03, TLV_NAME, 8'h02, 8'h61, 8'h62};
        send_packet(pkt);
        idle_on = 1'b1;
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.byte_in   = '0;
        in_if.last_byte = 1'b0;
        out_if.ready    = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_data_packets();
        test_control_packets();
        test_invalid_packets();
        test_backpressure();
        test_random_traffic();
        test_back_to_back();

        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d packets, %0d bytes sent, %0d results checked, %0d mismatches",
                 packets_sent, items_sent, results_seen, mismatches);
        $display("data, control and invalid packets, output stalls and gapless streams");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
